// ----- rtl/dttg_pkg.sv -----
`default_nettype none

package dttg_pkg;

  localparam int unsigned TableLength = 40;
  localparam int unsigned SampleBits  = 10;
  localparam int unsigned CounterBits = 16;
  localparam int unsigned NumRegs     = 8;
  localparam int unsigned NumKeys     = 4;
  localparam int unsigned PhaseBits   = $clog2(TableLength + 1);
  localparam int unsigned LevelBits   = SampleBits + 1;
  localparam int unsigned RegIdxBits  = $clog2(NumRegs);
  localparam int unsigned KeyIdxBits  = $clog2(NumKeys);
  localparam int unsigned CfgDataBits = 16;

  localparam logic [LevelBits-1:0] ReleaseLevel = LevelBits'(11'h3D8);
  localparam logic [LevelBits-1:0] ResetLevel   = LevelBits'(11'h0FF);
  localparam logic [PhaseBits-1:0] LastPhase    = PhaseBits'(TableLength - 1);

  // Register indexes of the configuration port.
  localparam logic [RegIdxBits-1:0] RegRowPeriod0 = RegIdxBits'(0);
  localparam logic [RegIdxBits-1:0] RegColPeriod0 = RegIdxBits'(4);

  typedef logic [CounterBits-1:0] period_t;
  typedef period_t [NumKeys-1:0] period_bank_t;

  typedef struct packed {
    logic                  key_down;
    logic [KeyIdxBits-1:0] key_row;
    logic [KeyIdxBits-1:0] key_col;
  } dttg_in_t;

  typedef struct packed {
    logic [LevelBits-1:0] dac_level;
    logic                 dac_update;
    logic                 tone_on;
  } dttg_out_t;

  typedef struct packed {
    period_bank_t row_period;
    period_bank_t col_period;
  } dttg_periods_t;

  // One period of the sine table; entries past the table read as zero.
  function automatic logic [SampleBits-1:0] wave_at(input logic [PhaseBits-1:0] phase);
    logic [9:0] w;
    case (phase)
      6'd0:  w = 10'h1ec;  6'd1:  w = 10'h239;  6'd2:  w = 10'h284;  6'd3:  w = 10'h2cb;
      6'd4:  w = 10'h30d;  6'd5:  w = 10'h348;  6'd6:  w = 10'h37a;  6'd7:  w = 10'h3a2;
      6'd8:  w = 10'h3c0;  6'd9:  w = 10'h3d2;  6'd10: w = 10'h3d8;  6'd11: w = 10'h3d2;
      6'd12: w = 10'h3c0;  6'd13: w = 10'h3a2;  6'd14: w = 10'h37a;  6'd15: w = 10'h348;
      6'd16: w = 10'h30d;  6'd17: w = 10'h2cb;  6'd18: w = 10'h284;  6'd19: w = 10'h239;
      6'd20: w = 10'h1ec;  6'd21: w = 10'h19f;  6'd22: w = 10'h154;  6'd23: w = 10'h10d;
      6'd24: w = 10'h0cb;  6'd25: w = 10'h090;  6'd26: w = 10'h05e;  6'd27: w = 10'h036;
      6'd28: w = 10'h018;  6'd29: w = 10'h006;  6'd30: w = 10'h000;  6'd31: w = 10'h006;
      6'd32: w = 10'h018;  6'd33: w = 10'h036;  6'd34: w = 10'h05e;  6'd35: w = 10'h090;
      6'd36: w = 10'h0cb;  6'd37: w = 10'h10d;  6'd38: w = 10'h154;  6'd39: w = 10'h19f;
      default: w = 10'h000;
    endcase
    return SampleBits'(w);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dttg_regs.sv -----
`default_nettype none

module dttg_regs (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [dttg_pkg::RegIdxBits-1:0]      cfg_index_i,
  input  wire logic [dttg_pkg::CfgDataBits-1:0]     cfg_data_i,
  output dttg_pkg::dttg_periods_t                   periods_o
);

  dttg_pkg::period_bank_t row_q, row_d;
  dttg_pkg::period_bank_t col_q, col_d;
  logic                   is_col;
  logic [dttg_pkg::KeyIdxBits-1:0] slot;

  assign cfg_ready_o = 1'b1;
  assign is_col = (cfg_index_i >= dttg_pkg::RegColPeriod0);
  assign slot   = dttg_pkg::KeyIdxBits'(cfg_index_i - (is_col ? dttg_pkg::RegColPeriod0
                                                              : dttg_pkg::RegRowPeriod0));

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_valid_i && cfg_ready_o) begin
      if (is_col) begin
        col_d[slot] = dttg_pkg::CounterBits'(cfg_data_i);
      end else begin
        row_d[slot] = dttg_pkg::CounterBits'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= dttg_pkg::CounterBits'(488);
      row_q[1] <= dttg_pkg::CounterBits'(441);
      row_q[2] <= dttg_pkg::CounterBits'(398);
      row_q[3] <= dttg_pkg::CounterBits'(360);
      col_q[0] <= dttg_pkg::CounterBits'(830);
      col_q[1] <= dttg_pkg::CounterBits'(752);
      col_q[2] <= dttg_pkg::CounterBits'(681);
      col_q[3] <= dttg_pkg::CounterBits'(615);
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign periods_o.row_period = row_q;
  assign periods_o.col_period = col_q;

endmodule

`default_nettype wire

// ----- rtl/dttg_core.sv -----
`default_nettype none

module dttg_core (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    step_i,
  input  wire dttg_pkg::dttg_in_t      item_i,
  input  wire dttg_pkg::dttg_periods_t periods_i,
  output dttg_pkg::dttg_out_t          result_o
);

  logic                                active_q, active_d;
  dttg_pkg::period_t                   col_cnt_q, col_cnt_d;
  dttg_pkg::period_t                   row_cnt_q, row_cnt_d;
  dttg_pkg::period_t                   col_per_q, col_per_d;
  dttg_pkg::period_t                   row_per_q, row_per_d;
  logic [dttg_pkg::PhaseBits-1:0]      col_ph_q, col_ph_d;
  logic [dttg_pkg::PhaseBits-1:0]      row_ph_q, row_ph_d;
  logic [dttg_pkg::LevelBits-1:0]      level_q, level_d;
  logic [dttg_pkg::PhaseBits-1:0]      col_ph_w, row_ph_w;
  logic                                col_flag, row_flag, update;

  assign col_flag = (col_cnt_q == '0);
  assign row_flag = (row_cnt_q == '0);
  assign col_ph_w = (col_ph_q > dttg_pkg::LastPhase) ? '0 : col_ph_q;
  assign row_ph_w = (row_ph_q > dttg_pkg::LastPhase) ? '0 : row_ph_q;

  always_comb begin
    active_d  = active_q;
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    col_per_d = col_per_q;
    row_per_d = row_per_q;
    col_ph_d  = col_ph_q;
    row_ph_d  = row_ph_q;
    level_d   = level_q;
    update    = 1'b0;
    if (!active_q) begin
      if (item_i.key_down) begin
        col_per_d = periods_i.col_period[item_i.key_col];
        row_per_d = periods_i.row_period[item_i.key_row];
        col_cnt_d = periods_i.col_period[item_i.key_col];
        row_cnt_d = periods_i.row_period[item_i.key_row];
        active_d  = 1'b1;
      end
    end else if (!item_i.key_down) begin
      active_d = 1'b0;
      level_d  = dttg_pkg::ReleaseLevel;
      update   = 1'b1;
    end else begin
      col_cnt_d = col_flag ? col_per_q : col_cnt_q - 1'b1;
      row_cnt_d = row_flag ? row_per_q : row_cnt_q - 1'b1;
      if (col_flag || row_flag) begin
        level_d  = dttg_pkg::LevelBits'(dttg_pkg::wave_at(col_ph_w))
                 + dttg_pkg::LevelBits'(dttg_pkg::wave_at(row_ph_w));
        update   = 1'b1;
        col_ph_d = col_flag ? col_ph_w + 1'b1 : col_ph_w;
        row_ph_d = row_flag ? row_ph_w + 1'b1 : row_ph_w;
      end
    end
  end

  assign result_o.dac_level  = level_d;
  assign result_o.dac_update = update;
  assign result_o.tone_on    = active_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      col_per_q <= '0;
      row_per_q <= '0;
      col_ph_q  <= '0;
      row_ph_q  <= '0;
      level_q   <= dttg_pkg::ResetLevel;
    end else if (step_i) begin
      active_q  <= active_d;
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      col_per_q <= col_per_d;
      row_per_q <= row_per_d;
      col_ph_q  <= col_ph_d;
      row_ph_q  <= row_ph_d;
      level_q   <= level_d;
    end
  end

  // Phases never run more than one step past the end of the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_ph_q <= dttg_pkg::PhaseBits'(dttg_pkg::TableLength)) &&
    (row_ph_q <= dttg_pkg::PhaseBits'(dttg_pkg::TableLength)))
    else $error("tone phase ran past the table");

  // A release rewrites the level to the midpoint.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && active_q && !item_i.key_down) |=>
      (level_q == dttg_pkg::ReleaseLevel) && !active_q)
    else $error("release did not set the midpoint level");

  // The start tick loads the counters but never rewrites the level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !active_q && item_i.key_down) |-> !update && result_o.tone_on)
    else $error("start tick rewrote the level");

  // The level moves only on a step that reports an update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_i && update) |=> $stable(level_q))
    else $error("level changed without an update");

endmodule

`default_nettype wire

// ----- rtl/dual_tone_table_generator_top.sv -----
// Dual-tone generator: each input transfer is one bus tick carrying the
// decoded key state (key_down, key_row, key_col); each tick yields exactly
// one output transfer with the converter level, an update flag and tone_on.
// Input and output channels use valid/stall; a transfer happens when valid
// is high and stall is low. The configuration channel (valid/ready, always
// ready) writes the eight period registers: index 0..3 row periods, 4..7
// column periods. Write it only while no tick is in flight.
// A tick is first held in the input register; once the result register
// is free, the tone logic (counter compare, two sine table reads and one
// add) computes the result from it and writes the result register, which
// offers the result on the output.
// Throughput is one tick per cycle while out_stall_i is low; the input register and the result
// register together decouple the two sides.
// While out_stall_i is high the result holds, the input register fills,
// and in_stall_o rises once both are occupied.
// Reset empties both registers, stops the tone, zeroes the counters and
// phases, sets the held level to 0xFF and loads the default periods.
`default_nettype none

module dual_tone_table_generator_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire dttg_pkg::dttg_in_t                in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output dttg_pkg::dttg_out_t                    out_data_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [dttg_pkg::RegIdxBits-1:0]   cfg_index_i,
  input  wire logic [dttg_pkg::CfgDataBits-1:0]  cfg_data_i
);

  logic                    s1_valid_q, s1_valid_d;
  dttg_pkg::dttg_in_t      s1_data_q;
  logic                    out_valid_q, out_valid_d;
  dttg_pkg::dttg_out_t     out_data_q;
  dttg_pkg::dttg_out_t     result;
  dttg_pkg::dttg_periods_t periods;
  logic                    out_free, step, in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_take || (s1_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && out_stall_i);

  dttg_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .periods_o   (periods)
  );

  dttg_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (s1_data_q),
    .periods_i (periods),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_data_i;
    end
    if (step) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
